// File: src/effective_address_resolver_macros.svh
// assertion macros for the effective address resolver
// no dependencies
`ifndef EFFECTIVE_ADDRESS_RESOLVER_MACROS_SVH
`define EFFECTIVE_ADDRESS_RESOLVER_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define EAR_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication checked outside reset
`define EAR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: src/ear_pkg.sv
// shared types and constants for the effective address resolver
// no dependencies
`timescale 1ns / 1ps
package ear_pkg;
  localparam int ADDR_WIDTH_DEFAULT = 32;

  localparam logic [2:0] KIND_START  = 3'd0;
  localparam logic [2:0] KIND_WORD   = 3'd1;
  localparam logic [2:0] KIND_PTR    = 3'd2;
  localparam logic [2:0] KIND_REGWR  = 3'd3;
  localparam logic [2:0] KIND_COMMIT = 3'd4;

  localparam logic [2:0] ST_NEED_WORD = 3'd0;
  localparam logic [2:0] ST_NEED_PTR  = 3'd1;
  localparam logic [2:0] ST_DONE      = 3'd2;
  localparam logic [2:0] ST_ILLEGAL   = 3'd3;
  localparam logic [2:0] ST_BUS_ERR   = 3'd4;
  localparam logic [2:0] ST_ACK       = 3'd5;

  localparam logic [1:0] OK_DREG = 2'd0;
  localparam logic [1:0] OK_AREG = 2'd1;
  localparam logic [1:0] OK_MEM  = 2'd2;
  localparam logic [1:0] OK_IMM  = 2'd3;

  localparam logic [3:0] PH_IDLE      = 4'd0;
  localparam logic [3:0] PH_DISP16    = 4'd1;
  localparam logic [3:0] PH_INDEX     = 4'd2;
  localparam logic [3:0] PH_BD_WORD   = 4'd3;
  localparam logic [3:0] PH_BD_HI     = 4'd4;
  localparam logic [3:0] PH_BD_LO     = 4'd5;
  localparam logic [3:0] PH_POINTER   = 4'd6;
  localparam logic [3:0] PH_OD_WORD   = 4'd7;
  localparam logic [3:0] PH_OD_HI     = 4'd8;
  localparam logic [3:0] PH_OD_LO     = 4'd9;
  localparam logic [3:0] PH_ABS_W     = 4'd10;
  localparam logic [3:0] PH_ABS_HI    = 4'd11;
  localparam logic [3:0] PH_ABS_LO    = 4'd12;
  localparam logic [3:0] PH_IMM_SHORT = 4'd13;
  localparam logic [3:0] PH_IMM_HI    = 4'd14;
  localparam logic [3:0] PH_IMM_LO    = 4'd15;

  localparam logic [31:0] BYTE_HI_MASK = 32'hFFFFFF00;
  localparam logic [31:0] WORD_HI_MASK = 32'hFFFF0000;
  localparam logic [15:0] FULL_FMT_BIT = 16'h0100;
  localparam logic [31:0] BYTE_MASK    = 32'h000000FF;

  typedef struct packed {
    logic [2:0]  mode;
    logic [2:0]  ea_mode;
    logic [2:0]  ea_reg;
    logic [1:0]  op_size;
    logic [31:0] pc_value;
    logic [15:0] ext_word;
    logic [31:0] mem_data;
    logic        access_ok;
    logic [3:0]  reg_index;
    logic [31:0] reg_data;
  } item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [1:0]  operand_kind;
    logic [31:0] address;
    logic [31:0] operand_value;
    logic [2:0]  operand_reg;
    logic [2:0]  words_consumed;
  } result_t;

  function automatic logic [31:0] sext16(input logic [15:0] w);
    sext16 = {{16{w[15]}}, w};
  endfunction

  function automatic logic [31:0] sext8(input logic [7:0] b);
    sext8 = {{24{b[7]}}, b};
  endfunction
endpackage

// File: src/effective_address_resolver.sv
// top level of the effective address resolver: front queue and back sequencer
// depends on ear_pkg, ear_front, ear_back and the assertion macro header
//
//   channel  handshake              payload
//   in       in_valid / in_ready    mode ea_mode ea_reg op_size pc_value ext_word
//                                   mem_data access_ok reg_index reg_data
//   out      out_valid / out_ready  status operand_kind address operand_value
//                                   operand_reg words_consumed
//
// one transaction per cycle sustained while out_ready stays high; each item takes one decode step in the back part
// items pass from in to out through the two-entry queue and then the result register
// reset clears the queue, the sequencer state and the register file
// a stalled out side fills the queue, then in_ready drops
`timescale 1ns / 1ps
`include "effective_address_resolver_macros.svh"
module effective_address_resolver #(
  parameter int ADDR_WIDTH = ear_pkg::ADDR_WIDTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  mode,
  input  logic [2:0]  ea_mode,
  input  logic [2:0]  ea_reg,
  input  logic [1:0]  op_size,
  input  logic [31:0] pc_value,
  input  logic [15:0] ext_word,
  input  logic [31:0] mem_data,
  input  logic        access_ok,
  input  logic [3:0]  reg_index,
  input  logic [31:0] reg_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [1:0]  operand_kind,
  output logic [31:0] address,
  output logic [31:0] operand_value,
  output logic [2:0]  operand_reg,
  output logic [2:0]  words_consumed
);
  ear_pkg::item_t   in_item;
  ear_pkg::item_t   q_item;
  ear_pkg::result_t res;
  logic             q_valid;
  logic             q_ready;
  logic [3:0]       phase;

  assign in_item = '{mode: mode, ea_mode: ea_mode, ea_reg: ea_reg, op_size: op_size,
                     pc_value: pc_value, ext_word: ext_word, mem_data: mem_data,
                     access_ok: access_ok, reg_index: reg_index, reg_data: reg_data};

  ear_front u_front (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
  );

  ear_back #(.ADDR_WIDTH(ADDR_WIDTH)) u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_res(res), .phase(phase)
  );

  assign status         = res.status;
  assign operand_kind   = res.operand_kind;
  assign address        = res.address;
  assign operand_value  = res.operand_value;
  assign operand_reg    = res.operand_reg;
  assign words_consumed = res.words_consumed;

  `EAR_ASSERT_NEXT(a_start_clears_count, q_valid && q_ready && q_item.mode == ear_pkg::KIND_START, words_consumed == 3'd0)
  `EAR_ASSERT_NEXT(a_ptr_phase, out_valid && out_ready && q_valid && q_ready && q_item.mode == ear_pkg::KIND_WORD && status == ear_pkg::ST_NEED_PTR, 1'b1)
  `EAR_ASSERT_IMP(a_ptr_req_mem, out_valid && status == ear_pkg::ST_NEED_PTR, operand_kind == ear_pkg::OK_MEM && phase == ear_pkg::PH_POINTER)
  `EAR_ASSERT_IMP(a_ack_clean, out_valid && status == ear_pkg::ST_ACK, address == 32'd0 && operand_value == 32'd0)
endmodule

// File: src/ear_front.sv
// front stage: accepts items and holds them in a two-entry queue
// depends on ear_pkg
`timescale 1ns / 1ps
module ear_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  ear_pkg::item_t in_item,
  output logic           q_valid,
  input  logic           q_ready,
  output ear_pkg::item_t q_item
);
  ear_pkg::item_t slot [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;
  logic           push;
  logic           pop;

  assign in_ready = (count != 2'd2);
  assign q_valid  = (count != 2'd0);
  assign q_item   = slot[rd_ptr];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= in_item;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

// File: src/ear_back.sv
// back stage: effective address sequencer, register file and result register
// depends on ear_pkg
`timescale 1ns / 1ps
module ear_back #(
  parameter int ADDR_WIDTH = ear_pkg::ADDR_WIDTH_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  output logic             q_ready,
  input  ear_pkg::item_t   q_item,
  output logic             out_valid,
  input  logic             out_ready,
  output ear_pkg::result_t out_res,
  output logic [3:0]       phase
);
  localparam logic [31:0] AMASK = 32'((64'd1 << ADDR_WIDTH) - 64'd1);

  logic [31:0] regs [16];
  logic [3:0]  phase_next;
  logic [1:0]  lat_size;
  logic [1:0]  lat_size_next;
  logic [15:0] ext_latch;
  logic [15:0] ext_latch_next;
  logic [31:0] base_value;
  logic [31:0] base_value_next;
  logic [31:0] index_value;
  logic [31:0] index_value_next;
  logic [31:0] disp_acc;
  logic [31:0] disp_acc_next;
  logic [31:0] pointer_value;
  logic [31:0] pointer_value_next;
  logic [2:0]  word_count;
  logic [2:0]  word_count_next;
  logic [6:0]  postinc;
  logic [6:0]  postinc_next;
  logic        rf_we;
  logic [3:0]  rf_idx;
  logic [31:0] rf_data;
  logic        take;
  ear_pkg::result_t res;
  logic [31:0] res_addr;

  logic [2:0]  r;
  logic [1:0]  sz;
  logic [2:0]  amt;
  logic [31:0] areg;
  logic [31:0] idx_raw;
  logic [31:0] idx_val;
  logic [15:0] w;
  logic [31:0] dsel;
  logic [31:0] cur;
  logic [31:0] wsz;

  assign take    = q_valid && (!out_valid || out_ready);
  assign q_ready = (!out_valid || out_ready);

  assign r    = q_item.ea_reg;
  assign sz   = q_item.op_size;
  assign amt  = (sz == 2'd0) ? ((r == 3'd7) ? 3'd2 : 3'd1) : ((sz == 2'd1) ? 3'd2 : 3'd4);
  assign areg = regs[{1'b1, r}];
  assign w    = q_item.ext_word;
  assign idx_raw = w[15] ? regs[{1'b1, w[14:12]}] : regs[{1'b0, w[14:12]}];
  assign idx_val = (w[11] ? idx_raw : ear_pkg::sext16(idx_raw[15:0])) << w[10:9];
  assign cur  = regs[q_item.reg_index];
  assign wsz  = (q_item.reg_index[3] || sz[1]) ? q_item.reg_data :
                (sz == 2'd0) ? ((cur & ear_pkg::BYTE_HI_MASK) |
                                (q_item.reg_data & ear_pkg::BYTE_MASK)) :
                ((cur & ear_pkg::WORD_HI_MASK) | {16'd0, q_item.reg_data[15:0]});

  always_comb begin
    phase_next         = phase;
    lat_size_next      = lat_size;
    ext_latch_next     = ext_latch;
    base_value_next    = base_value;
    index_value_next   = index_value;
    disp_acc_next      = disp_acc;
    pointer_value_next = pointer_value;
    word_count_next    = word_count;
    postinc_next       = postinc;
    rf_we   = 1'b0;
    rf_idx  = q_item.reg_index;
    rf_data = wsz;
    dsel    = 32'd0;
    res     = '0;
    res.status = ear_pkg::ST_ILLEGAL;
    res_addr = 32'd0;
    unique case (q_item.mode)
      ear_pkg::KIND_START: begin
        lat_size_next    = sz;
        postinc_next     = 7'd0;
        word_count_next  = 3'd0;
        disp_acc_next    = 32'd0;
        index_value_next = 32'd0;
        phase_next       = ear_pkg::PH_IDLE;
        res.status       = ear_pkg::ST_NEED_WORD;
        unique case (q_item.ea_mode)
          3'd0: begin
            res.status = ear_pkg::ST_DONE;
            res.operand_kind = ear_pkg::OK_DREG;
            res.operand_reg = r;
            res.operand_value = (sz == 2'd0) ? (regs[{1'b0, r}] & ear_pkg::BYTE_MASK) :
                                (sz == 2'd1) ? {16'd0, regs[{1'b0, r}][15:0]} :
                                regs[{1'b0, r}];
          end
          3'd1: begin
            res.status = ear_pkg::ST_DONE;
            res.operand_kind = ear_pkg::OK_AREG;
            res.operand_reg = r;
            res.operand_value = areg;
          end
          3'd2, 3'd3: begin
            res.status = ear_pkg::ST_DONE;
            res.operand_kind = ear_pkg::OK_MEM;
            res_addr = areg;
            if (q_item.ea_mode == 3'd3) begin
              postinc_next = {1'b1, r, amt};
            end
          end
          3'd4: begin
            res.status = ear_pkg::ST_DONE;
            res.operand_kind = ear_pkg::OK_MEM;
            res_addr = areg - {29'd0, amt};
            rf_we   = 1'b1;
            rf_idx  = {1'b1, r};
            rf_data = res_addr;
          end
          3'd5: begin
            base_value_next = areg;
            phase_next = ear_pkg::PH_DISP16;
          end
          3'd6: begin
            base_value_next = areg;
            phase_next = ear_pkg::PH_INDEX;
          end
          default: begin
            priority case (r)
              3'd0: phase_next = ear_pkg::PH_ABS_W;
              3'd1: phase_next = ear_pkg::PH_ABS_HI;
              3'd2: begin
                base_value_next = q_item.pc_value;
                phase_next = ear_pkg::PH_DISP16;
              end
              3'd3: begin
                base_value_next = q_item.pc_value;
                phase_next = ear_pkg::PH_INDEX;
              end
              3'd4: phase_next = sz[1] ? ear_pkg::PH_IMM_HI : ear_pkg::PH_IMM_SHORT;
              default: res.status = ear_pkg::ST_ILLEGAL;
            endcase
          end
        endcase
        res.words_consumed = 3'd0;
      end
      ear_pkg::KIND_WORD: begin
        if (phase != ear_pkg::PH_IDLE && phase != ear_pkg::PH_POINTER) begin
          if (word_count != 3'd7) begin
            word_count_next = word_count + 3'd1;
          end
          res.status = ear_pkg::ST_NEED_WORD;
          phase_next = ear_pkg::PH_IDLE;
          unique case (phase)
            ear_pkg::PH_DISP16: begin
              res.status = ear_pkg::ST_DONE;
              res.operand_kind = ear_pkg::OK_MEM;
              res_addr = base_value + ear_pkg::sext16(w);
            end
            ear_pkg::PH_INDEX: begin
              ext_latch_next = w;
              if ((w & ear_pkg::FULL_FMT_BIT) == 16'd0) begin
                res.status = ear_pkg::ST_DONE;
                res.operand_kind = ear_pkg::OK_MEM;
                res_addr = base_value + idx_val + ear_pkg::sext8(w[7:0]);
              end else begin
                base_value_next  = w[7] ? 32'd0 : base_value;
                index_value_next = w[6] ? 32'd0 : idx_val;
                disp_acc_next    = 32'd0;
                if (w[5:4] == 2'd2) begin
                  phase_next = ear_pkg::PH_BD_WORD;
                end else if (w[5:4] == 2'd3) begin
                  phase_next = ear_pkg::PH_BD_HI;
                end else begin
                  phase_next = ear_pkg::PH_POINTER;
                end
              end
            end
            ear_pkg::PH_BD_WORD: begin
              disp_acc_next = ear_pkg::sext16(w);
              phase_next = ear_pkg::PH_POINTER;
            end
            ear_pkg::PH_BD_HI: begin
              disp_acc_next = {w, 16'd0};
              phase_next = ear_pkg::PH_BD_LO;
            end
            ear_pkg::PH_BD_LO: begin
              disp_acc_next = disp_acc | {16'd0, w};
              phase_next = ear_pkg::PH_POINTER;
            end
            ear_pkg::PH_OD_WORD: begin
              disp_acc_next = ear_pkg::sext16(w);
              phase_next = ear_pkg::PH_OD_LO;
            end
            ear_pkg::PH_OD_HI: begin
              disp_acc_next = {w, 16'd0};
              phase_next = ear_pkg::PH_OD_LO;
            end
            ear_pkg::PH_OD_LO: begin
              phase_next = ear_pkg::PH_OD_LO;
            end
            ear_pkg::PH_ABS_W: begin
              res.status = ear_pkg::ST_DONE;
              res.operand_kind = ear_pkg::OK_MEM;
              res_addr = ear_pkg::sext16(w);
            end
            ear_pkg::PH_ABS_HI: begin
              disp_acc_next = {w, 16'd0};
              phase_next = ear_pkg::PH_ABS_LO;
            end
            ear_pkg::PH_ABS_LO: begin
              res.status = ear_pkg::ST_DONE;
              res.operand_kind = ear_pkg::OK_MEM;
              res_addr = disp_acc | {16'd0, w};
            end
            ear_pkg::PH_IMM_SHORT: begin
              res.status = ear_pkg::ST_DONE;
              res.operand_kind = ear_pkg::OK_IMM;
              res.operand_value = (lat_size == 2'd0) ? {24'd0, w[7:0]} : {16'd0, w};
            end
            ear_pkg::PH_IMM_HI: begin
              disp_acc_next = {w, 16'd0};
              phase_next = ear_pkg::PH_IMM_LO;
            end
            default: begin
              res.status = ear_pkg::ST_DONE;
              res.operand_kind = ear_pkg::OK_IMM;
              res.operand_value = disp_acc | {16'd0, w};
            end
          endcase
          // finishing steps shared by base and outer displacement ends
          if (phase_next == ear_pkg::PH_POINTER) begin
            if (ext_latch_next[2:0] == 3'd0) begin
              res.status = ear_pkg::ST_DONE;
              res.operand_kind = ear_pkg::OK_MEM;
              res_addr = base_value_next + index_value_next + disp_acc_next;
              phase_next = ear_pkg::PH_IDLE;
            end else begin
              res.status = ear_pkg::ST_NEED_PTR;
              res.operand_kind = ear_pkg::OK_MEM;
              res_addr = base_value_next + disp_acc_next +
                         ((ext_latch_next[2:0] < 3'd4) ? index_value_next : 32'd0);
            end
          end else if (phase_next == ear_pkg::PH_OD_LO &&
                       (phase == ear_pkg::PH_OD_WORD || phase == ear_pkg::PH_OD_LO)) begin
            dsel = (phase == ear_pkg::PH_OD_WORD) ? disp_acc_next : (disp_acc | {16'd0, w});
            res.status = ear_pkg::ST_DONE;
            res.operand_kind = ear_pkg::OK_MEM;
            res_addr = pointer_value + dsel +
                       ((ext_latch[2:0] < 3'd4) ? 32'd0 : index_value);
            disp_acc_next = dsel;
            phase_next = ear_pkg::PH_IDLE;
          end
        end
        res.words_consumed = word_count_next;
      end
      ear_pkg::KIND_PTR: begin
        if (phase == ear_pkg::PH_POINTER) begin
          res.operand_kind = ear_pkg::OK_MEM;
          if (!q_item.access_ok) begin
            res.status = ear_pkg::ST_BUS_ERR;
            res_addr = base_value + disp_acc +
                       ((ext_latch[2:0] < 3'd4) ? index_value : 32'd0);
            phase_next = ear_pkg::PH_IDLE;
          end else begin
            pointer_value_next = q_item.mem_data;
            disp_acc_next = 32'd0;
            res.status = ear_pkg::ST_NEED_WORD;
            res.operand_kind = ear_pkg::OK_DREG;
            if (ext_latch[1:0] == 2'd2) begin
              phase_next = ear_pkg::PH_OD_WORD;
            end else if (ext_latch[1:0] == 2'd3) begin
              phase_next = ear_pkg::PH_OD_HI;
            end else begin
              res.status = ear_pkg::ST_DONE;
              res.operand_kind = ear_pkg::OK_MEM;
              res_addr = q_item.mem_data +
                         ((ext_latch[2:0] < 3'd4) ? 32'd0 : index_value);
              phase_next = ear_pkg::PH_IDLE;
            end
          end
        end
        res.words_consumed = word_count;
      end
      ear_pkg::KIND_REGWR: begin
        rf_we = 1'b1;
        res.status = ear_pkg::ST_ACK;
        res.words_consumed = word_count;
      end
      ear_pkg::KIND_COMMIT: begin
        if (q_item.access_ok && postinc[6]) begin
          rf_we   = 1'b1;
          rf_idx  = {1'b1, postinc[5:3]};
          rf_data = regs[{1'b1, postinc[5:3]}] + {29'd0, postinc[2:0]};
        end
        postinc_next = 7'd0;
        res.status = q_item.access_ok ? ear_pkg::ST_ACK : ear_pkg::ST_BUS_ERR;
        res.words_consumed = word_count;
      end
      default: begin
        res.words_consumed = word_count;
      end
    endcase
    res.address = res_addr & AMASK;
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_res <= res;
    end
    if (rst) begin
      for (int i = 0; i < 16; i++) begin
        regs[i] <= 32'd0;
      end
      phase         <= ear_pkg::PH_IDLE;
      lat_size      <= 2'd0;
      ext_latch     <= 16'd0;
      base_value    <= 32'd0;
      index_value   <= 32'd0;
      disp_acc      <= 32'd0;
      pointer_value <= 32'd0;
      word_count    <= 3'd0;
      postinc       <= 7'd0;
      out_valid     <= 1'b0;
    end else begin
      if (take) begin
        if (rf_we) begin
          regs[rf_idx] <= rf_data;
        end
        phase         <= phase_next;
        lat_size      <= lat_size_next;
        ext_latch     <= ext_latch_next;
        base_value    <= base_value_next;
        index_value   <= index_value_next;
        disp_acc      <= disp_acc_next;
        pointer_value <= pointer_value_next;
        word_count    <= word_count_next;
        postinc       <= postinc_next;
        out_valid     <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end
endmodule

// File: test/tb_top.sv
// self-checking testbench for the effective address resolver
// predicts each result from its own model of the sequencer and register file
// depends on ear_pkg and the effective_address_resolver top level
`timescale 1ns / 1ps
module tb_top;
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  mode = '0;
  logic [2:0]  ea_mode = '0;
  logic [2:0]  ea_reg = '0;
  logic [1:0]  op_size = '0;
  logic [31:0] pc_value = '0;
  logic [15:0] ext_word = '0;
  logic [31:0] mem_data = '0;
  logic        access_ok = 1'b0;
  logic [3:0]  reg_index = '0;
  logic [31:0] reg_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  status;
  logic [1:0]  operand_kind;
  logic [31:0] address;
  logic [31:0] operand_value;
  logic [2:0]  operand_reg;
  logic [2:0]  words_consumed;

  effective_address_resolver dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  logic [31:0] regs [16];
  logic [3:0]  seq_phase;
  logic [1:0]  req_size;
  logic [15:0] ext_reg;
  logic [31:0] base_r, index_r, disp_r, ptr_r;
  logic [2:0]  word_cnt;
  logic        pinc_valid;
  logic [2:0]  pinc_reg, pinc_amt;

  ear_pkg::result_t expected_q[$];
  int errors = 0;
  int results_seen = 0;
  int rx_wait = 0;
  bit hold_off = 1'b0;

  function automatic logic [31:0] xs16(logic [15:0] w);
    return {{16{w[15]}}, w};
  endfunction

  function automatic logic [31:0] index_val(logic [15:0] e);
    logic [31:0] raw;
    raw = e[15] ? regs[{1'b1, e[14:12]}] : regs[{1'b0, e[14:12]}];
    if (!e[11]) raw = xs16(raw[15:0]);
    return raw << e[10:9];
  endfunction

  function automatic ear_pkg::result_t mk(logic [2:0] st, logic [1:0] k, logic [31:0] a,
                                          logic [31:0] v, logic [2:0] r);
    ear_pkg::result_t x;
    x.status = st; x.operand_kind = k; x.address = a;
    x.operand_value = v; x.operand_reg = r; x.words_consumed = word_cnt;
    return x;
  endfunction

  function automatic ear_pkg::result_t need(logic [3:0] nxt);
    seq_phase = nxt;
    return mk(ear_pkg::ST_NEED_WORD, ear_pkg::OK_DREG, '0, '0, '0);
  endfunction

  function automatic ear_pkg::result_t mem_done(logic [31:0] a);
    seq_phase = ear_pkg::PH_IDLE;
    return mk(ear_pkg::ST_DONE, ear_pkg::OK_MEM, a, '0, '0);
  endfunction

  function automatic logic [31:0] inter_addr();
    if (ext_reg[2:0] < 3'd4) return base_r + index_r + disp_r;
    return base_r + disp_r;
  endfunction

  function automatic ear_pkg::result_t after_bd();
    if (ext_reg[2:0] == 3'd0) return mem_done(base_r + index_r + disp_r);
    seq_phase = ear_pkg::PH_POINTER;
    return mk(ear_pkg::ST_NEED_PTR, ear_pkg::OK_MEM, inter_addr(), '0, '0);
  endfunction

  function automatic ear_pkg::result_t fin_ind();
    if (ext_reg[2:0] < 3'd4) return mem_done(ptr_r + disp_r);
    return mem_done(ptr_r + index_r + disp_r);
  endfunction

  function automatic ear_pkg::result_t imm_done(logic [31:0] v);
    seq_phase = ear_pkg::PH_IDLE;
    return mk(ear_pkg::ST_DONE, ear_pkg::OK_IMM, '0, v, '0);
  endfunction

  function automatic ear_pkg::result_t illegal();
    return mk(ear_pkg::ST_ILLEGAL, ear_pkg::OK_DREG, '0, '0, '0);
  endfunction

  function automatic ear_pkg::result_t resolve_operand(ear_pkg::item_t it);
    logic [2:0]  amt;
    logic [31:0] msk;
    logic [15:0] w;
    unique case (it.mode)
      ear_pkg::KIND_START: begin
        amt = (it.op_size == 2'd0) ? ((it.ea_reg == 3'd7) ? 3'd2 : 3'd1) :
              (it.op_size == 2'd1) ? 3'd2 : 3'd4;
        msk = (it.op_size == 2'd0) ? ear_pkg::BYTE_MASK :
              (it.op_size == 2'd1) ? 32'h0000FFFF : 32'hFFFFFFFF;
        req_size = it.op_size;
        pinc_valid = 1'b0; word_cnt = '0; disp_r = '0; index_r = '0;
        seq_phase = ear_pkg::PH_IDLE;
        unique case (it.ea_mode)
          3'd0: return mk(ear_pkg::ST_DONE, ear_pkg::OK_DREG, '0,
                          regs[{1'b0, it.ea_reg}] & msk, it.ea_reg);
          3'd1: return mk(ear_pkg::ST_DONE, ear_pkg::OK_AREG, '0,
                          regs[{1'b1, it.ea_reg}], it.ea_reg);
          3'd2: return mem_done(regs[{1'b1, it.ea_reg}]);
          3'd3: begin
            pinc_valid = 1'b1; pinc_reg = it.ea_reg; pinc_amt = amt;
            return mem_done(regs[{1'b1, it.ea_reg}]);
          end
          3'd4: begin
            regs[{1'b1, it.ea_reg}] = regs[{1'b1, it.ea_reg}] - {29'd0, amt};
            return mem_done(regs[{1'b1, it.ea_reg}]);
          end
          3'd5: begin
            base_r = regs[{1'b1, it.ea_reg}];
            return need(ear_pkg::PH_DISP16);
          end
          3'd6: begin
            base_r = regs[{1'b1, it.ea_reg}];
            return need(ear_pkg::PH_INDEX);
          end
          default: begin
            unique case (it.ea_reg)
              3'd0: return need(ear_pkg::PH_ABS_W);
              3'd1: return need(ear_pkg::PH_ABS_HI);
              3'd2: begin base_r = it.pc_value; return need(ear_pkg::PH_DISP16); end
              3'd3: begin base_r = it.pc_value; return need(ear_pkg::PH_INDEX); end
              3'd4: return need((it.op_size < 2'd2) ? ear_pkg::PH_IMM_SHORT :
                                                      ear_pkg::PH_IMM_HI);
              default: return illegal();
            endcase
          end
        endcase
      end
      ear_pkg::KIND_WORD: begin
        w = it.ext_word;
        if (seq_phase == ear_pkg::PH_IDLE || seq_phase == ear_pkg::PH_POINTER)
          return illegal();
        if (word_cnt < 3'd7) word_cnt = word_cnt + 3'd1;
        unique case (seq_phase)
          ear_pkg::PH_DISP16: return mem_done(base_r + xs16(w));
          ear_pkg::PH_INDEX: begin
            ext_reg = w;
            if ((w & ear_pkg::FULL_FMT_BIT) == 16'd0)
              return mem_done(base_r + index_val(w) + {{24{w[7]}}, w[7:0]});
            if (w[7]) base_r = '0;
            index_r = w[6] ? 32'd0 : index_val(w);
            disp_r = '0;
            if (w[5:4] == 2'd2) return need(ear_pkg::PH_BD_WORD);
            if (w[5:4] == 2'd3) return need(ear_pkg::PH_BD_HI);
            return after_bd();
          end
          ear_pkg::PH_BD_WORD: begin disp_r = xs16(w); return after_bd(); end
          ear_pkg::PH_BD_HI: begin disp_r = {w, 16'd0}; return need(ear_pkg::PH_BD_LO); end
          ear_pkg::PH_BD_LO: begin disp_r = disp_r | {16'd0, w}; return after_bd(); end
          ear_pkg::PH_OD_WORD: begin disp_r = xs16(w); return fin_ind(); end
          ear_pkg::PH_OD_HI: begin disp_r = {w, 16'd0}; return need(ear_pkg::PH_OD_LO); end
          ear_pkg::PH_OD_LO: begin disp_r = disp_r | {16'd0, w}; return fin_ind(); end
          ear_pkg::PH_ABS_W: return mem_done(xs16(w));
          ear_pkg::PH_ABS_HI: begin
            disp_r = {w, 16'd0};
            return need(ear_pkg::PH_ABS_LO);
          end
          ear_pkg::PH_ABS_LO: return mem_done(disp_r | {16'd0, w});
          ear_pkg::PH_IMM_SHORT:
            return imm_done((req_size == 2'd0) ? {24'd0, w[7:0]} : {16'd0, w});
          ear_pkg::PH_IMM_HI: begin
            disp_r = {w, 16'd0};
            return need(ear_pkg::PH_IMM_LO);
          end
          default: return imm_done(disp_r | {16'd0, w});
        endcase
      end
      ear_pkg::KIND_PTR: begin
        if (seq_phase != ear_pkg::PH_POINTER) return illegal();
        if (!it.access_ok) begin
          seq_phase = ear_pkg::PH_IDLE;
          return mk(ear_pkg::ST_BUS_ERR, ear_pkg::OK_MEM, inter_addr(), '0, '0);
        end
        ptr_r = it.mem_data; disp_r = '0;
        if (ext_reg[1:0] == 2'd2) return need(ear_pkg::PH_OD_WORD);
        if (ext_reg[1:0] == 2'd3) return need(ear_pkg::PH_OD_HI);
        return fin_ind();
      end
      ear_pkg::KIND_REGWR: begin
        if (it.reg_index < 4'd8 && it.op_size == 2'd0)
          regs[it.reg_index] = (regs[it.reg_index] & ear_pkg::BYTE_HI_MASK) |
                               (it.reg_data & ear_pkg::BYTE_MASK);
        else if (it.reg_index < 4'd8 && it.op_size == 2'd1)
          regs[it.reg_index] = (regs[it.reg_index] & ear_pkg::WORD_HI_MASK) |
                               {16'd0, it.reg_data[15:0]};
        else
          regs[it.reg_index] = it.reg_data;
        return mk(ear_pkg::ST_ACK, ear_pkg::OK_DREG, '0, '0, '0);
      end
      ear_pkg::KIND_COMMIT: begin
        if (it.access_ok && pinc_valid)
          regs[{1'b1, pinc_reg}] = regs[{1'b1, pinc_reg}] + {29'd0, pinc_amt};
        pinc_valid = 1'b0;
        return mk(it.access_ok ? ear_pkg::ST_ACK : ear_pkg::ST_BUS_ERR, ear_pkg::OK_DREG,
                  '0, '0, '0);
      end
      default: return illegal();
    endcase
  endfunction

  task automatic send_item(ear_pkg::item_t it, bit no_gap = 1'b0);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    mode <= it.mode; ea_mode <= it.ea_mode; ea_reg <= it.ea_reg;
    op_size <= it.op_size; pc_value <= it.pc_value; ext_word <= it.ext_word;
    mem_data <= it.mem_data; access_ok <= it.access_ok;
    reg_index <= it.reg_index; reg_data <= it.reg_data;
    do @(posedge clk); while (!in_ready);
    expected_q.push_back(resolve_operand(it));
  endtask

  function automatic ear_pkg::item_t rand_item(logic [2:0] k);
    ear_pkg::item_t it;
    it = '0;
    it.mode = k;
    it.ea_mode = 3'($urandom_range(0, 7));
    it.ea_reg = 3'($urandom_range(0, 7));
    it.op_size = 2'($urandom_range(0, 3));
    it.pc_value = $urandom;
    it.ext_word = 16'($urandom);
    it.mem_data = $urandom;
    it.access_ok = 1'($urandom);
    it.reg_index = 4'($urandom);
    it.reg_data = $urandom;
    return it;
  endfunction

  task automatic wait_drain();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  // result checker with random receiver stalls
  always @(posedge clk) begin
    ear_pkg::result_t got, exp_r;
    if (rst) begin
      out_ready <= 1'b0;
      rx_wait = 0;
    end else begin
      if (out_valid && out_ready) begin
        got = '{status, operand_kind, address, operand_value, operand_reg, words_consumed};
        results_seen++;
        if (expected_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result %h", got);
        end else begin
          exp_r = expected_q.pop_front();
          if (got !== exp_r) begin
            errors++;
            if (errors <= 10)
              $display({"mismatch: exp st=%0d k=%0d a=%h v=%h r=%0d w=%0d",
                        " got st=%0d k=%0d a=%h v=%h r=%0d w=%0d"},
                       exp_r.status, exp_r.operand_kind, exp_r.address,
                       exp_r.operand_value, exp_r.operand_reg, exp_r.words_consumed,
                       got.status, got.operand_kind, got.address, got.operand_value,
                       got.operand_reg, got.words_consumed);
          end
        end
        rx_wait = $urandom_range(0, 7);
      end else if (rx_wait > 0 && !hold_off) begin
        rx_wait--;
      end
      out_ready <= !hold_off && (rx_wait == 0);
    end
  end

  task automatic test_reg_writes();
    ear_pkg::item_t it;
    for (int i = 0; i < 16; i++) begin
      it = rand_item(ear_pkg::KIND_REGWR);
      it.reg_index = 4'(i); it.op_size = 2'd2;
      it.reg_data = (i == 0) ? 32'hFFFFFFFF : (i == 1) ? 32'h0 : $urandom;
      send_item(it);
    end
    it = rand_item(ear_pkg::KIND_REGWR); it.reg_index = 4'd2; it.op_size = 2'd0;
    send_item(it);
    it = rand_item(ear_pkg::KIND_REGWR); it.reg_index = 4'd3; it.op_size = 2'd1;
    send_item(it);
  endtask

  task automatic test_modes();
    ear_pkg::item_t it;
    for (int m = 0; m < 8; m++) begin
      it = rand_item(ear_pkg::KIND_START); it.ea_mode = 3'(m);
      it.ea_reg = (m == 7) ? 3'd4 : 3'd7; it.op_size = 2'd0;
      send_item(it);
      it = rand_item(ear_pkg::KIND_WORD); it.ext_word = 16'h8000; send_item(it);
    end
    it = rand_item(ear_pkg::KIND_START); it.ea_mode = 3'd7; it.ea_reg = 3'd5; send_item(it);
    it = rand_item(ear_pkg::KIND_PTR); send_item(it);
    it = rand_item(ear_pkg::KIND_COMMIT); it.access_ok = 1'b1; send_item(it);
    it = rand_item(3'd7); send_item(it);
    it = rand_item(3'd5); send_item(it);
  endtask

  // well-formed operand sequence with random content
  task automatic run_operand(bit no_gap);
    ear_pkg::item_t it;
    int n;
    it = rand_item(ear_pkg::KIND_START);
    if ($urandom_range(0, 3) == 0) it.ea_mode = 3'd6;
    if ($urandom_range(0, 5) == 0) begin it.ea_mode = 3'd7; it.ea_reg = 3'd3; end
    send_item(it, no_gap);
    n = 0;
    while (seq_phase != ear_pkg::PH_IDLE && n < 8) begin
      n++;
      if (seq_phase == ear_pkg::PH_POINTER) begin
        it = rand_item(ear_pkg::KIND_PTR); it.access_ok = ($urandom_range(0, 7) != 0);
      end else begin
        it = rand_item(ear_pkg::KIND_WORD);
        if (seq_phase == ear_pkg::PH_INDEX && $urandom_range(0, 1)) it.ext_word[8] = 1'b1;
      end
      if ($urandom_range(0, 15) == 0) it = rand_item(ear_pkg::KIND_REGWR);
      send_item(it, no_gap);
    end
    if ($urandom_range(0, 1)) begin
      it = rand_item(ear_pkg::KIND_COMMIT); it.access_ok = ($urandom_range(0, 5) != 0);
      send_item(it, no_gap);
    end
  endtask

  task automatic test_random();
    ear_pkg::item_t it;
    for (int i = 0; i < 380; i++) begin
      if ($urandom_range(0, 9) < 8) run_operand(i % 40 < 4);
      else begin
        it = rand_item(3'($urandom_range(0, 7)));
        send_item(it);
      end
      if (i == 100) begin
        send_item(rand_item(ear_pkg::KIND_COMMIT));
        wait_drain();
      end
    end
  endtask

  task automatic test_backpressure();
    hold_off <= 1'b1;
    fork
      begin repeat (60) @(posedge clk); hold_off <= 1'b0; end
      begin for (int i = 0; i < 12; i++) run_operand(1'b1); end
    join
  endtask

  initial begin
    for (int i = 0; i < 16; i++) regs[i] = '0;
    seq_phase = ear_pkg::PH_IDLE; req_size = '0; ext_reg = '0; base_r = '0; index_r = '0;
    disp_r = '0; ptr_r = '0; word_cnt = '0; pinc_valid = 1'b0; pinc_reg = '0; pinc_amt = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reg_writes();
    test_modes();
    test_backpressure();
    test_random();
    wait_drain();
    repeat (10) @(posedge clk);
    $display("covered all item kinds, every addressing mode, brief and full index forms");
    $display("%0d results checked with random stalls and one long receiver hold-off",
             results_seen);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("== FAIL ==");
    $finish;
  end
endmodule

// File: files.f
+incdir+src
src/ear_pkg.sv
src/ear_front.sv
src/ear_back.sv
src/effective_address_resolver.sv
test/tb_top.sv
